### hw/rtl/admx_pkg.sv
// ----------------------------------------------------------------------------
// admx_pkg: shared types and constants for the arcade drive mixer
// Register indexes, reset values, blend weights and stage enable struct.
// ----------------------------------------------------------------------------
package admx_pkg;

	localparam int NUM_STAGES = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STICK_DB   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_THR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_DB     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_THR   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MV_PER_PCT = 3'd7;

	// reset values
	localparam logic [6:0] RST_STICK_DB   = 7'd10;
	localparam logic [6:0] RST_FAST_THR   = 7'd60;
	localparam logic [8:0] RST_SLOW_GAIN  = 9'd166;
	localparam logic [8:0] RST_FAST_GAIN  = 9'd205;
	localparam logic [6:0] RST_OUT_DB     = 7'd5;
	localparam logic [6:0] RST_STOP_SPEED = 7'd7;
	localparam logic [7:0] RST_JUMP_THR   = 8'd50;
	localparam logic [7:0] RST_MV_PER_PCT = 8'd130;

	// Q8 blend weights
	localparam logic [8:0] K_FULL = 9'd256;
	localparam logic [8:0] K_HIGH = 9'd205;
	localparam logic [8:0] K_HALF = 9'd128;
	localparam logic [8:0] K_LOW  = 9'd46;

	// Q8 target clamp, +-100 percent
	localparam logic signed [18:0] TGT_MAX = 19'sd25600;
	localparam logic signed [18:0] TGT_MIN = -19'sd25600;

	// load enables for the blend stages of each side
	typedef struct packed {
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} stage_en_t;

endpackage

### hw/rtl/admx_side.sv
// ----------------------------------------------------------------------------
// admx_side: blend and millivolt scaling for one drive side
// Four register stages: weight products, sum, scale, round and saturate.
// ----------------------------------------------------------------------------
module admx_side (
	input  logic                     clk,
	input  admx_pkg::stage_en_t      en,
	input  logic [8:0]               k,
	input  logic signed [15:0]       target,
	input  logic signed [8:0]        meas,
	input  logic [7:0]               mv_per_pct,
	input  logic                     coast,
	output logic signed [15:0]       drive_mv
);

	logic [8:0]         k_comp;
	logic signed [25:0] pt_s5;
	logic signed [18:0] po_s5;
	logic               coast_s5;
	logic signed [25:0] blend_s6;
	logic               coast_s6;
	logic signed [34:0] x_s7;
	logic               coast_s7;
	logic signed [35:0] xr;
	logic signed [19:0] q;
	logic signed [15:0] sat;
	logic signed [15:0] drive_s8;

	assign k_comp = admx_pkg::K_FULL - k;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			pt_s5    <= $signed({1'b0, k}) * target;
			po_s5    <= $signed({1'b0, k_comp}) * meas;
			coast_s5 <= coast;
		end
		if (en.s6) begin
			blend_s6 <= pt_s5 + $signed({po_s5, 7'b0});
			coast_s6 <= coast_s5;
		end
		if (en.s7) begin
			x_s7     <= blend_s6 * $signed({1'b0, mv_per_pct});
			coast_s7 <= coast_s6;
		end
		if (en.s8) begin
			drive_s8 <= coast_s7 ? 16'sd0 : sat;
		end
	end

	// round half up, floor by 2^16
	always_comb begin
		xr = 36'(x_s7) + 36'sd32768;
		q  = xr[35:16];
		if (q > 20'sd32767)
			sat = 16'sd32767;
		else if (q < -20'sd32768)
			sat = -16'sd32768;
		else
			sat = q[15:0];
	end

	assign drive_mv = drive_s8;

endmodule

### hw/rtl/arcade_drive_mixer_with_slew_blend_top.sv
// ----------------------------------------------------------------------------
// arcade_drive_mixer_with_slew_blend_top: arcade drive mixer with speed blend
// Depth: 8 register stages from input to output.
// Throughput: one item per cycle while out_stall is low; each stage holds at most one item.
// A stalled output holds only the stages behind it that are full; bubbles close up.
// Reset clears all valid bits and loads the register defaults; data needs none.
// ----------------------------------------------------------------------------
module arcade_drive_mixer_with_slew_blend_top (
	input  logic                                 clk,
	input  logic                                 arst_n,

	// configuration
	input  logic                                 cfg_wr_en,
	input  logic [admx_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [admx_pkg::CFG_DATA_W-1:0]      cfg_data,

	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [7:0]                    forward_stick,
	input  logic signed [7:0]                    turn_stick,
	input  logic signed [7:0]                    left_front_speed,
	input  logic signed [7:0]                    left_rear_speed,
	input  logic signed [7:0]                    right_front_speed,
	input  logic signed [7:0]                    right_rear_speed,

	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [15:0]                   left_drive_mv,
	output logic signed [15:0]                   right_drive_mv,
	output logic                                 coast_stop
);

	localparam int NS = admx_pkg::NUM_STAGES;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [6:0] stick_db_q;
	logic [6:0] fast_thr_q;
	logic [8:0] slow_gain_q;
	logic [8:0] fast_gain_q;
	logic [6:0] out_db_q;
	logic [6:0] stop_speed_q;
	logic [7:0] jump_thr_q;
	logic [7:0] mv_per_pct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_db_q   <= admx_pkg::RST_STICK_DB;
			fast_thr_q   <= admx_pkg::RST_FAST_THR;
			slow_gain_q  <= admx_pkg::RST_SLOW_GAIN;
			fast_gain_q  <= admx_pkg::RST_FAST_GAIN;
			out_db_q     <= admx_pkg::RST_OUT_DB;
			stop_speed_q <= admx_pkg::RST_STOP_SPEED;
			jump_thr_q   <= admx_pkg::RST_JUMP_THR;
			mv_per_pct_q <= admx_pkg::RST_MV_PER_PCT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				admx_pkg::REG_STICK_DB:   stick_db_q   <= cfg_data[6:0];
				admx_pkg::REG_FAST_THR:   fast_thr_q   <= cfg_data[6:0];
				admx_pkg::REG_SLOW_GAIN:  slow_gain_q  <= cfg_data;
				admx_pkg::REG_FAST_GAIN:  fast_gain_q  <= cfg_data;
				admx_pkg::REG_OUT_DB:     out_db_q     <= cfg_data[6:0];
				admx_pkg::REG_STOP_SPEED: stop_speed_q <= cfg_data[6:0];
				admx_pkg::REG_JUMP_THR:   jump_thr_q   <= cfg_data[7:0];
				admx_pkg::REG_MV_PER_PCT: mv_per_pct_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: a stage loads when it is empty or its successor
	// loads, so bubbles close up behind a stalled output.
	// ------------------------------------------------------------------
	logic [NS:1]   stage_vld_q;
	logic [NS:1]   load;
	logic [NS-1:0] vld_in;

	always_comb begin
		load[NS] = !stage_vld_q[NS] || !out_stall;
		for (int i = NS - 1; i >= 1; i--) begin
			load[i] = !stage_vld_q[i] || load[i+1];
		end
		vld_in[0] = in_valid;
		for (int i = 1; i <= NS - 1; i++) begin
			vld_in[i] = stage_vld_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			for (int i = 1; i <= NS; i++) begin
				if (load[i]) stage_vld_q[i] <= vld_in[i-1];
			end
		end
	end

	assign in_stall = !load[1];

	// ------------------------------------------------------------------
	// Stage 1: stick deadband, turn gain pick, per-side speed sums
	// ------------------------------------------------------------------
	logic signed [8:0] fwd_x, turn_x, fwd_abs_x, turn_abs_x;
	logic [7:0]        fwd_abs, turn_abs, turn_abs_db;
	logic              fwd_zero, turn_zero;

	logic signed [7:0] fwd_s1, turn_s1;
	logic [8:0]        gain_s1;
	logic signed [8:0] lo_s1, ro_s1;

	always_comb begin
		fwd_x       = {forward_stick[7], forward_stick};
		turn_x      = {turn_stick[7], turn_stick};
		fwd_abs_x   = fwd_x[8] ? -fwd_x : fwd_x;
		turn_abs_x  = turn_x[8] ? -turn_x : turn_x;
		fwd_abs     = fwd_abs_x[7:0];
		turn_abs    = turn_abs_x[7:0];
		fwd_zero    = fwd_abs < {1'b0, stick_db_q};
		turn_zero   = turn_abs < {1'b0, stick_db_q};
		turn_abs_db = turn_zero ? 8'd0 : turn_abs;
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			fwd_s1  <= fwd_zero ? 8'sd0 : forward_stick;
			turn_s1 <= turn_zero ? 8'sd0 : turn_stick;
			gain_s1 <= (turn_abs_db > {1'b0, fast_thr_q}) ? fast_gain_q : slow_gain_q;
			lo_s1   <= $signed({left_front_speed[7], left_front_speed})
			         + $signed({left_rear_speed[7], left_rear_speed});
			ro_s1   <= $signed({right_front_speed[7], right_front_speed})
			         + $signed({right_rear_speed[7], right_rear_speed});
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: turn times gain (Q8)
	// ------------------------------------------------------------------
	logic signed [17:0] prod_s2;
	logic signed [7:0]  fwd_s2;
	logic signed [8:0]  lo_s2, ro_s2;

	always_ff @(posedge clk) begin
		if (load[2]) begin
			prod_s2 <= turn_s1 * $signed({1'b0, gain_s1});
			fwd_s2  <= fwd_s1;
			lo_s2   <= lo_s1;
			ro_s2   <= ro_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: mix, clamp to +-100 percent, output deadband
	// ------------------------------------------------------------------
	logic signed [18:0] fwd_q8, prod_x, lsum, rsum;
	logic signed [15:0] lt_c, rt_c, lt_sh, rt_sh;
	logic [15:0]        lt_abs, rt_abs;

	logic signed [15:0] lt_s3, rt_s3;
	logic signed [8:0]  lo_s3, ro_s3;

	always_comb begin
		fwd_q8 = {{3{fwd_s2[7]}}, fwd_s2, 8'b0};
		prod_x = {prod_s2[17], prod_s2};
		lsum   = fwd_q8 + prod_x;
		rsum   = fwd_q8 - prod_x;

		if (lsum > admx_pkg::TGT_MAX)      lt_c = admx_pkg::TGT_MAX[15:0];
		else if (lsum < admx_pkg::TGT_MIN) lt_c = admx_pkg::TGT_MIN[15:0];
		else                               lt_c = lsum[15:0];

		if (rsum > admx_pkg::TGT_MAX)      rt_c = admx_pkg::TGT_MAX[15:0];
		else if (rsum < admx_pkg::TGT_MIN) rt_c = admx_pkg::TGT_MIN[15:0];
		else                               rt_c = rsum[15:0];

		lt_abs = lt_c[15] ? 16'(-lt_c) : 16'(lt_c);
		rt_abs = rt_c[15] ? 16'(-rt_c) : 16'(rt_c);
		lt_sh  = (lt_abs < {1'b0, out_db_q, 8'b0}) ? 16'sd0 : lt_c;
		rt_sh  = (rt_abs < {1'b0, out_db_q, 8'b0}) ? 16'sd0 : rt_c;
	end

	always_ff @(posedge clk) begin
		if (load[3]) begin
			lt_s3 <= lt_sh;
			rt_s3 <= rt_sh;
			lo_s3 <= lo_s2;
			ro_s3 <= ro_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: coast decision, reversal and jump tests, weight pick
	// ------------------------------------------------------------------
	logic signed [8:0]  lo_abs_x, ro_abs_x;
	logic [8:0]         lo_abs, ro_abs;
	logic signed [17:0] ldiff, rdiff;
	logic [17:0]        ldiff_abs, rdiff_abs;
	logic               coast, lrev, rrev, ljump, rjump;
	logic [8:0]         k_sel;

	logic               coast_s4;
	logic [8:0]         k_s4;
	logic signed [15:0] lt_s4, rt_s4;
	logic signed [8:0]  lo_s4, ro_s4;

	always_comb begin
		lo_abs_x = lo_s3[8] ? -lo_s3 : lo_s3;
		ro_abs_x = ro_s3[8] ? -ro_s3 : ro_s3;
		lo_abs   = lo_abs_x;
		ro_abs   = ro_abs_x;
		coast    = (lt_s3 == 16'sd0) && (rt_s3 == 16'sd0)
		        && (lo_abs < {1'b0, stop_speed_q, 1'b0})
		        && (ro_abs < {1'b0, stop_speed_q, 1'b0});

		lrev = ((lt_s3 > 16'sd0) && (lo_s3 < 9'sd0)) || ((lt_s3 < 16'sd0) && (lo_s3 > 9'sd0));
		rrev = ((rt_s3 > 16'sd0) && (ro_s3 < 9'sd0)) || ((rt_s3 < 16'sd0) && (ro_s3 > 9'sd0));

		ldiff     = {{2{lt_s3[15]}}, lt_s3} - {{2{lo_s3[8]}}, lo_s3, 7'b0};
		rdiff     = {{2{rt_s3[15]}}, rt_s3} - {{2{ro_s3[8]}}, ro_s3, 7'b0};
		ldiff_abs = ldiff[17] ? 18'(-ldiff) : 18'(ldiff);
		rdiff_abs = rdiff[17] ? 18'(-rdiff) : 18'(rdiff);
		ljump     = ldiff_abs > {2'b0, jump_thr_q, 8'b0};
		rjump     = rdiff_abs > {2'b0, jump_thr_q, 8'b0};

		if (lrev && rrev)
			k_sel = (ljump && rjump) ? admx_pkg::K_LOW : admx_pkg::K_HALF;
		else if (lrev || rrev)
			k_sel = (ljump || rjump) ? admx_pkg::K_HALF : admx_pkg::K_HIGH;
		else
			k_sel = (ljump && rjump) ? admx_pkg::K_HIGH : admx_pkg::K_FULL;
	end

	always_ff @(posedge clk) begin
		if (load[4]) begin
			coast_s4 <= coast;
			k_s4     <= k_sel;
			lt_s4    <= lt_s3;
			rt_s4    <= rt_s3;
			lo_s4    <= lo_s3;
			ro_s4    <= ro_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stages 5-8: blend, scale to millivolts, saturate (one unit per side)
	// ------------------------------------------------------------------
	admx_pkg::stage_en_t blend_en;

	assign blend_en.s5 = load[5];
	assign blend_en.s6 = load[6];
	assign blend_en.s7 = load[7];
	assign blend_en.s8 = load[8];

	admx_side u_left (
		.clk        (clk),
		.en         (blend_en),
		.k          (k_s4),
		.target     (lt_s4),
		.meas       (lo_s4),
		.mv_per_pct (mv_per_pct_q),
		.coast      (coast_s4),
		.drive_mv   (left_drive_mv)
	);

	admx_side u_right (
		.clk        (clk),
		.en         (blend_en),
		.k          (k_s4),
		.target     (rt_s4),
		.meas       (ro_s4),
		.mv_per_pct (mv_per_pct_q),
		.coast      (coast_s4),
		.drive_mv   (right_drive_mv)
	);

	// carry the coast flag alongside the side units
	logic coast_s5, coast_s6, coast_s7, coast_s8;

	always_ff @(posedge clk) begin
		if (load[5]) coast_s5 <= coast_s4;
		if (load[6]) coast_s6 <= coast_s5;
		if (load[7]) coast_s7 <= coast_s6;
		if (load[8]) coast_s8 <= coast_s7;
	end

	assign out_valid  = stage_vld_q[NS];
	assign coast_stop = coast_s8;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_coast_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && coast_stop |-> left_drive_mv == 16'sd0 && right_drive_mv == 16'sd0)
		else $error("coast result carries nonzero drive");

	a_empty_out_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output stage is empty");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> stage_vld_q[1])
		else $error("accepted transfer did not reach first stage");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_drive_mv)
			&& $stable(right_drive_mv) && $stable(coast_stop))
		else $error("stalled result changed");

endmodule

### dv/tb_arcade_drive_mixer_with_slew_blend_top.sv
// ----------------------------------------------------------------------------
// tb_arcade_drive_mixer_with_slew_blend_top: self-checking bench for the mixer
// Drives stick and motor speed samples through the valid/stall channels and
// predicts each drive result in a scoreboard class. Each output transfer is
// compared field by field. The run covers several register settings,
// random idling on both sides, and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_arcade_drive_mixer_with_slew_blend_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REG_COUNT   = 8;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_CYCLES = 80;

	// Register widths and the in-range top of each register, by register index.
	localparam int REG_MASK [REG_COUNT] = '{'h7F, 'h7F, 'h1FF, 'h1FF, 'h7F, 'h7F, 'hFF, 'hFF};
	localparam int REG_HIGH [REG_COUNT] = '{100, 100, 256, 256, 100, 127, 255, 255};
	localparam int REG_RESET[REG_COUNT] = '{admx_pkg::RST_STICK_DB, admx_pkg::RST_FAST_THR,
		admx_pkg::RST_SLOW_GAIN, admx_pkg::RST_FAST_GAIN, admx_pkg::RST_OUT_DB,
		admx_pkg::RST_STOP_SPEED, admx_pkg::RST_JUMP_THR, admx_pkg::RST_MV_PER_PCT};

	typedef enum {CFG_DEFAULT, CFG_RANDOM, CFG_ZERO, CFG_ALL_ONES, CFG_WILD} cfg_mode_t;

	typedef struct {
		logic signed [7:0] fwd;
		logic signed [7:0] turn;
		logic signed [7:0] lf;
		logic signed [7:0] lr;
		logic signed [7:0] rf;
		logic signed [7:0] rr;
	} stick_sample_t;

	typedef struct {
		logic signed [15:0] left_mv;
		logic signed [15:0] right_mv;
		logic               coast;
	} drive_out_t;

	// Scoreboard: own copy of the registers, a queue of predicted drive results.
	class drive_ledger;
		int         regs[REG_COUNT];
		drive_out_t drive_due[$];
		int         errors;
		int         noted;
		int         checked;
		int         coasts;

		function new();
			foreach (regs[i]) regs[i] = REG_RESET[i];
		endfunction

		function void set_reg(int idx, int data);
			regs[idx] = data & REG_MASK[idx];
		endfunction

		function int outstanding();
			return drive_due.size();
		endfunction

		function longint mag(longint v);
			return (v < 0) ? -v : v;
		endfunction

		function bit opposite(longint tgt, longint meas);
			return (tgt > 0 && meas < 0) || (tgt < 0 && meas > 0);
		endfunction

		// Clamp a Q8 target to +-100 percent, then drop it inside the output deadband.
		function longint shape_q8(longint t);
			if (t > longint'(admx_pkg::TGT_MAX)) t = longint'(admx_pkg::TGT_MAX);
			if (t < longint'(admx_pkg::TGT_MIN)) t = longint'(admx_pkg::TGT_MIN);
			if (mag(t) < longint'(regs[admx_pkg::REG_OUT_DB]) * 256) t = 0;
			return t;
		endfunction

		// Blend Q8 target with Q1 side sum, scale to mV, round half up, saturate.
		function logic signed [15:0] millivolts(longint k, longint tgt_q8, longint sum_q1);
			longint blend;
			longint scaled;
			longint q;
			blend  = k * tgt_q8 + (256 - k) * sum_q1 * 128;
			scaled = blend * longint'(regs[admx_pkg::REG_MV_PER_PCT]) + 32768;
			q = scaled >>> 16;
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			return q[15:0];
		endfunction

		function void note_input(stick_sample_t s);
			longint     fwd, turn, gain, lt, rt, lsum, rsum, k, jmp, stop2;
			bit         lrev, rrev, ljump, rjump;
			drive_out_t r;
			fwd  = s.fwd;
			turn = s.turn;
			if (mag(turn) < regs[admx_pkg::REG_STICK_DB]) turn = 0;
			if (mag(fwd) < regs[admx_pkg::REG_STICK_DB]) fwd = 0;
			gain = (mag(turn) > regs[admx_pkg::REG_FAST_THR]) ?
				regs[admx_pkg::REG_FAST_GAIN] : regs[admx_pkg::REG_SLOW_GAIN];
			lt = shape_q8(fwd * 256 + turn * gain);
			rt = shape_q8(fwd * 256 - turn * gain);
			lsum  = longint'(s.lf) + longint'(s.lr);
			rsum  = longint'(s.rf) + longint'(s.rr);
			stop2 = 2 * longint'(regs[admx_pkg::REG_STOP_SPEED]);
			noted++;
			if (lt == 0 && rt == 0 && mag(lsum) < stop2 && mag(rsum) < stop2) begin
				r.left_mv  = '0;
				r.right_mv = '0;
				r.coast    = 1'b1;
				coasts++;
				drive_due.push_back(r);
				return;
			end
			jmp   = longint'(regs[admx_pkg::REG_JUMP_THR]) * 256;
			lrev  = opposite(lt, lsum);
			rrev  = opposite(rt, rsum);
			ljump = mag(lt - lsum * 128) > jmp;
			rjump = mag(rt - rsum * 128) > jmp;
			if (lrev && rrev)
				k = (ljump && rjump) ? admx_pkg::K_LOW : admx_pkg::K_HALF;
			else if (lrev || rrev)
				k = (ljump || rjump) ? admx_pkg::K_HALF : admx_pkg::K_HIGH;
			else
				k = (ljump && rjump) ? admx_pkg::K_HIGH : admx_pkg::K_FULL;
			r.left_mv  = millivolts(k, lt, lsum);
			r.right_mv = millivolts(k, rt, rsum);
			r.coast    = 1'b0;
			drive_due.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(drive_out_t got);
			drive_out_t want;
			if (drive_due.size() == 0) begin
				report("drive result with no sample outstanding");
				return;
			end
			want = drive_due.pop_front();
			checked++;
			if (got.left_mv !== want.left_mv)
				report($sformatf("left_drive_mv got %0d want %0d", got.left_mv, want.left_mv));
			if (got.right_mv !== want.right_mv)
				report($sformatf("right_drive_mv got %0d want %0d", got.right_mv, want.right_mv));
			if (got.coast !== want.coast)
				report($sformatf("coast_stop got %0b want %0b", got.coast, want.coast));
		endtask
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wr_en = 1'b0;
	logic [admx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [admx_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic signed [7:0]               forward_stick = '0;
	logic signed [7:0]               turn_stick = '0;
	logic signed [7:0]               left_front_speed = '0;
	logic signed [7:0]               left_rear_speed = '0;
	logic signed [7:0]               right_front_speed = '0;
	logic signed [7:0]               right_rear_speed = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic signed [15:0]              left_drive_mv;
	logic signed [15:0]              right_drive_mv;
	logic                            coast_stop;

	drive_ledger ledger = new();

	int src_idle_pct = 0;       // chance per cycle that the sender holds back
	int snk_idle_pct = 0;       // chance per cycle that the receiver stalls
	bit hold_req = 1'b0;        // ask the receiver for one long hold-off
	int hold_left = 0;
	int in_stall_cycles = 0;
	int settings_used = 1;
	int cycle_count;

	arcade_drive_mixer_with_slew_blend_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.forward_stick    (forward_stick),
		.turn_stick       (turn_stick),
		.left_front_speed (left_front_speed),
		.left_rear_speed  (left_rear_speed),
		.right_front_speed(right_front_speed),
		.right_rear_speed (right_rear_speed),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.left_drive_mv    (left_drive_mv),
		.right_drive_mv   (right_drive_mv),
		.coast_stop       (coast_stop)
	);

	// 20 ns clock: low half, then high half.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random stalls, or one long hold-off counted here so that the
	// pipeline backs up all the way to the input while the sender keeps offering.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
		end
	end

	// Output monitor: check every result transfer against the oldest prediction; also count input stalls.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			ledger.check_result('{left_drive_mv, right_drive_mv, coast_stop});
		if (arst_n && in_valid && in_stall)
			in_stall_cycles++;
	end

	// Watchdog: end the run if the stimulus never drains.
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("Timeout after %0d cycles, %0d results outstanding",
			cycle_count, ledger.outstanding());
		$display("Some tests failed");
		$finish;
	end

	function automatic int pick(int lo, int hi);
		return int'($urandom_range(0, hi - lo)) + lo;
	endfunction

	function automatic stick_sample_t mk(int fwd, int turn, int lf, int lr, int rf, int rr);
		stick_sample_t s;
		s.fwd  = fwd[7:0];
		s.turn = turn[7:0];
		s.lf   = lf[7:0];
		s.lr   = lr[7:0];
		s.rf   = rf[7:0];
		s.rr   = rr[7:0];
		return s;
	endfunction

	// Mix of sample shapes: near-rest (coast region), full 8-bit noise,
	// direction reversals, and ordinary driving.
	function automatic stick_sample_t random_sample();
		int kind;
		int fwd;
		int dir;
		kind = pick(0, 9);
		if (kind < 2)
			return mk(pick(-12, 12), pick(-12, 12), pick(-10, 10), pick(-10, 10),
				pick(-10, 10), pick(-10, 10));
		if (kind == 2)
			return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (kind < 5) begin
			fwd = pick(-100, 100);
			dir = (fwd < 0) ? 1 : -1;
			return mk(fwd, pick(-30, 30), dir * pick(0, 127), dir * pick(0, 127),
				dir * pick(0, 127), dir * pick(0, 127));
		end
		return mk(pick(-100, 100), pick(-100, 100), pick(-127, 127), pick(-127, 127),
			pick(-127, 127), pick(-127, 127));
	endfunction

	// Offer one sample and hold it until the transfer happens.
	task automatic send_sample(stick_sample_t s);
		in_valid          <= 1'b1;
		forward_stick     <= s.fwd;
		turn_stick        <= s.turn;
		left_front_speed  <= s.lf;
		left_rear_speed   <= s.lr;
		right_front_speed <= s.rf;
		right_rear_speed  <= s.rr;
		do
			@(posedge clk);
		while (in_stall);
		ledger.note_input(s);
	endtask

	task automatic send_random(int count);
		for (int n = 0; n < count; n++) begin
			while ($urandom_range(0, 99) < src_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			send_sample(random_sample());
		end
		in_valid <= 1'b0;
	endtask

	// Wait out every prediction, then let the pipeline settle before touching registers.
	task automatic drain();
		while (ledger.outstanding() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(int idx, int data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx[admx_pkg::CFG_IDX_W-1:0];
		cfg_data  <= data[admx_pkg::CFG_DATA_W-1:0];
		ledger.set_reg(idx, data[admx_pkg::CFG_DATA_W-1:0]);
		@(posedge clk);
	endtask

	task automatic load_settings(cfg_mode_t mode);
		int data;
		for (int i = 0; i < REG_COUNT; i++) begin
			case (mode)
				CFG_DEFAULT:  data = REG_RESET[i];
				CFG_RANDOM:   data = pick(0, REG_HIGH[i]);
				CFG_ZERO:     data = 0;
				CFG_ALL_ONES: data = (1 << admx_pkg::CFG_DATA_W) - 1;
				default:      data = pick(0, (1 << admx_pkg::CFG_DATA_W) - 1);
			endcase
			write_reg(i, data);
		end
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Directed samples under the reset settings: deadband and threshold edges,
	// every blend weight branch, coast stop and its near misses, field extremes.
	task automatic send_directed();
		send_sample(mk(0, 0, 0, 0, 0, 0));              // coast at rest
		send_sample(mk(9, -9, 3, -3, 6, -6));           // sticks inside deadband
		send_sample(mk(10, 0, 0, 0, 0, 0));             // stick on deadband edge
		send_sample(mk(0, 0, 7, 7, 0, 0));              // left speed at stop_speed
		send_sample(mk(0, 0, 6, 7, -7, -6));            // just under stop_speed
		send_sample(mk(100, 0, 0, 0, 0, 0));
		send_sample(mk(-100, 0, 0, 0, 0, 0));
		send_sample(mk(0, 60, 0, 0, 0, 0));             // turn on threshold: slow gain
		send_sample(mk(0, 61, 0, 0, 0, 0));             // just above: fast gain
		send_sample(mk(0, -100, 0, 0, 0, 0));
		send_sample(mk(100, 100, 100, 100, 100, 100));  // left clamps
		send_sample(mk(-100, -100, -100, -100, -100, -100));
		send_sample(mk(100, 0, -100, -100, -100, -100)); // both reverse, both jump
		send_sample(mk(30, 0, -10, -10, -10, -10));     // both reverse, no jump
		send_sample(mk(100, 0, -20, -20, 100, 100));    // one reverses, jump
		send_sample(mk(30, 0, -5, -5, 30, 30));         // one reverses, no jump
		send_sample(mk(100, 0, 10, 10, 10, 10));        // no reversal, both jump
		send_sample(mk(40, 0, 40, 40, 40, 40));         // no reversal, no jump
		send_sample(mk(10, -10, 0, 0, 0, 0));           // left cancels into output deadband
		send_sample(mk(-128, -128, -128, -128, -128, -128));
		send_sample(mk(127, 127, 127, 127, 127, 127));
		send_sample(mk(127, -128, -128, 127, 127, -128));
		send_sample(mk(-101, 101, 0, 0, 0, 0));
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		drain();

		// Sender mostly busy, receiver mostly stalled.
		src_idle_pct = 21;
		snk_idle_pct = 80;
		load_settings(CFG_RANDOM);
		send_random(PHASE_ITEMS);
		drain();
		load_settings(CFG_ZERO);
		send_random(PHASE_ITEMS);
		drain();

		// Swap: sparse sender, eager receiver.
		src_idle_pct = 80;
		snk_idle_pct = 21;
		load_settings(CFG_ALL_ONES);
		send_random(PHASE_ITEMS);
		drain();
		load_settings(CFG_WILD);
		send_random(PHASE_ITEMS);
		drain();

		// No idling; first phase starts with a long receiver hold-off to fill the pipe.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		load_settings(CFG_RANDOM);
		hold_req = 1'b1;
		send_random(PHASE_ITEMS);
		drain();
		load_settings(CFG_DEFAULT);
		send_random(PHASE_ITEMS);
		drain();
		load_settings(CFG_RANDOM);
		send_random(PHASE_ITEMS);
		drain();

		$display("Run covered %0d sample transfers and %0d checked results (%0d coast stops)",
			ledger.noted, ledger.checked, ledger.coasts);
		$display("over %0d register settings; input stalled %0d cycles, %0d mismatches",
			settings_used, in_stall_cycles, ledger.errors);
		if (ledger.errors == 0 && ledger.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/admx_pkg.sv
hw/rtl/admx_side.sv
hw/rtl/arcade_drive_mixer_with_slew_blend_top.sv
dv/tb_arcade_drive_mixer_with_slew_blend_top.sv
